/* rtl/hough_map_derivative_accumulator_macros.svh */
// assertion macros shared by the hough map derivative accumulator rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef HOUGH_MAP_DERIVATIVE_ACCUMULATOR_MACROS_SVH
`define HOUGH_MAP_DERIVATIVE_ACCUMULATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HMDA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define HMDA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hmda_pkg.sv */
// shared types and codes for the hough map derivative accumulator
// no dependencies
`timescale 1ns / 1ps

package hmda_pkg;

	// default sizes of the map store
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_USE_WEIGHT = 2'd2
	} reg_idx_t;

	// request operations
	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_FIRST = 3'd1,
		OP_LEFT  = 3'd2,
		OP_RIGHT = 3'd3,
		OP_INTEG = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DROP = 2'd1,
		STAT_OOB  = 2'd2
	} status_t;

	// clamped configuration seen by the datapath
	typedef struct packed {
		logic [6:0] w;
		logic [6:0] h;
		logic       use_weight;
	} cfg_t;

endpackage

/* rtl/hmda_cfg.sv */
// apb register file for the hough map derivative accumulator
// depends on hmda_pkg; hands clamped map sizes to the datapath
`timescale 1ns / 1ps

module hmda_cfg
	import hmda_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [6:0] map_width_q;
	logic [6:0] map_height_q;
	logic       use_weight_q;
	logic       wr_en;
	reg_idx_t   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= 7'd64;
			map_height_q <= 7'd64;
			use_weight_q <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAP_WIDTH:  map_width_q  <= pwdata[6:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[6:0];
				REG_USE_WEIGHT: use_weight_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_MAP_WIDTH:  prdata = {25'd0, map_width_q};
			REG_MAP_HEIGHT: prdata = {25'd0, map_height_q};
			REG_USE_WEIGHT: prdata = {31'd0, use_weight_q};
			default:        prdata = '0;
		endcase
	end

	// zero reads as one, anything past the store size as the maximum
	always_comb begin
		if (map_width_q == 7'd0)
			cfg.w = 7'd1;
		else if (11'(map_width_q) > 11'(MAX_WIDTH))
			cfg.w = 7'(MAX_WIDTH);
		else
			cfg.w = map_width_q;
		if (map_height_q == 7'd0)
			cfg.h = 7'd1;
		else if (11'(map_height_q) > 11'(MAX_HEIGHT))
			cfg.h = 7'(MAX_HEIGHT);
		else
			cfg.h = map_height_q;
		cfg.use_weight = use_weight_q;
	end

endmodule

/* rtl/hough_map_derivative_accumulator.sv */
// Hough derivative map held in one single-port synchronous RAM with a row integrator.
// Depends on hmda_pkg, hmda_cfg and hough_map_derivative_accumulator_macros.svh.
`timescale 1ns / 1ps
`include "hough_map_derivative_accumulator_macros.svh"

// The map holds MAX_HEIGHT*(MAX_WIDTH+1) words of 32 bits in one single-port RAM
// with a registered read; requests are handled one at a time. After reset the
// block sweeps all MAX_HEIGHT*(MAX_WIDTH+1) words (4160 at the defaults) to zero,
// one word a cycle, with in_ready low; register writes are taken during the sweep.
// A clear request runs the same sweep and then returns its result. A first column
// or border request passes through decode, address check with the read, write
// back and result; a border request past the end of the map skips the write back,
// and a dropped row or unknown operation goes from decode straight to the result.
// An integrate request decodes and then reads and accumulates each column in turn,
// map_width results in all, each waiting while the output register is full.
// A result waits in an output register, so the next request is taken while the
// last result is still unread.
module hough_map_derivative_accumulator
	import hmda_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic signed [10:0] row,
	input  logic [6:0]         x_pixel,
	input  logic [7:0]         column_count,
	input  logic signed [15:0] weight,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         column,
	output logic signed [31:0] total,
	output logic               last
);

	localparam int STORE_DEPTH = MAX_HEIGHT * (MAX_WIDTH + 1);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IDX_W       = $clog2(STORE_DEPTH + 128);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_CALC    = 8'b0000_0010,
		S_ADDR    = 8'b0000_0100,
		S_MOD     = 8'b0000_1000,
		S_EMIT    = 8'b0001_0000,
		S_INT_RD  = 8'b0010_0000,
		S_INT_ACC = 8'b0100_0000,
		S_CLEAR   = 8'b1000_0000
	} state_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31])
			sat33 = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			sat33 = v[31:0];
	endfunction

	cfg_t cfg;

	hmda_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t                    state_q, state_d;
	logic [ADDR_W-1:0]         clr_q;
	logic                      clr_report_q;
	logic                      out_valid_q;

	// request fields
	op_t                       op_q;
	logic signed [10:0]        row_q;
	logic [6:0]                xp_q;
	logic [7:0]                cnt_q;
	logic signed [15:0]        wt_q;

	// working registers
	logic [ADDR_W-1:0]         base_q;
	logic [ADDR_W-1:0]         addr_q;
	logic signed [24:0]        delta_q;
	status_t                   st_q, st_d;
	logic [5:0]                col_q;
	logic signed [31:0]        acc_q;

	// result register
	status_t                   status_q;
	logic [5:0]                column_q;
	logic signed [31:0]        total_q;
	logic                      last_q;

	// map store
	logic [31:0]               map_q [STORE_DEPTH];
	logic signed [31:0]        rdata_q;
	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_addr;
	logic [31:0]               mem_wdata;

	logic [7:0]                stride;
	logic [IDX_W-1:0]          limit;
	logic                      row_ok;
	logic [ADDR_W-1:0]         base_calc;
	logic signed [24:0]        prod;
	logic [IDX_W-1:0]          idx;
	logic                      oob;
	logic signed [32:0]        mod_sum;
	logic signed [32:0]        int_sum;
	logic [ADDR_W-1:0]         int_addr;
	logic                      int_last;
	logic                      clr_done;
	logic                      out_free;
	logic                      out_load;
	status_t                   ld_status;
	logic [5:0]                ld_col;
	logic signed [31:0]        ld_total;
	logic                      ld_last;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign column    = column_q;
	assign total     = total_q;
	assign last      = last_q;
	assign out_free  = !out_valid_q || out_ready;

	// row geometry
	assign stride    = {1'b0, cfg.w} + 8'd1;
	assign limit     = IDX_W'({7'd0, cfg.h} * {6'd0, stride});
	assign row_ok    = !row_q[10] && (row_q[9:0] < {3'd0, cfg.h});
	assign base_calc = ADDR_W'({7'd0, row_q[6:0]} * {6'd0, stride});
	assign prod      = $signed({1'b0, cnt_q}) * wt_q;

	// entry index and bound check
	assign idx = (op_q == OP_FIRST) ? IDX_W'(base_q) : IDX_W'(base_q) + IDX_W'(xp_q);
	assign oob = (op_q != OP_FIRST) && (idx >= limit);

	// read-modify-write and running sum adders
	assign mod_sum  = $signed({rdata_q[31], rdata_q}) + $signed({{8{delta_q[24]}}, delta_q});
	assign int_sum  = $signed({acc_q[31], acc_q}) + $signed({rdata_q[31], rdata_q});
	assign int_addr = base_q + ADDR_W'(col_q);
	assign int_last = ({1'b0, col_q} + 7'd1) == cfg.w;
	assign clr_done = (clr_q == ADDR_W'(STORE_DEPTH - 1));

	// sequencer
	always_comb begin
		state_d   = state_q;
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_addr  = clr_q;
		mem_wdata = '0;
		out_load  = 1'b0;
		ld_status = STAT_OK;
		ld_col    = '0;
		ld_total  = '0;
		ld_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_CALC;
			end
			S_CALC: begin
				st_d = STAT_OK;
				case (op_q)
					OP_CLEAR: state_d = S_CLEAR;
					OP_FIRST, OP_LEFT, OP_RIGHT: begin
						state_d = row_ok ? S_ADDR : S_EMIT;
						if (!row_ok)
							st_d = STAT_DROP;
					end
					OP_INTEG: begin
						state_d = row_ok ? S_INT_RD : S_EMIT;
						if (!row_ok)
							st_d = STAT_DROP;
					end
					default: state_d = S_EMIT;
				endcase
			end
			S_ADDR: begin
				mem_addr = ADDR_W'(idx);
				if (oob) begin
					st_d    = STAT_OOB;
					state_d = S_EMIT;
				end else begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				mem_addr  = addr_q;
				mem_we    = 1'b1;
				mem_wdata = sat33(mod_sum);
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_status = st_q;
					state_d   = S_IDLE;
				end
			end
			S_INT_RD: begin
				mem_addr = int_addr;
				state_d  = S_INT_ACC;
			end
			S_INT_ACC: begin
				mem_addr = int_addr;
				if (out_free) begin
					out_load = 1'b1;
					ld_col   = col_q;
					ld_total = sat33(int_sum);
					ld_last  = int_last;
					state_d  = int_last ? S_IDLE : S_INT_RD;
				end
			end
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_done)
					state_d = clr_report_q ? S_EMIT : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			clr_report_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CALC && op_q == OP_CLEAR) begin
				clr_q        <= '0;
				clr_report_q <= 1'b1;
			end else if (state_q == S_CLEAR && !clr_done) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= op_t'(operation);
			row_q <= row;
			xp_q  <= x_pixel;
			cnt_q <= column_count;
			wt_q  <= cfg.use_weight ? weight : 16'sd1;
		end
		if (state_q == S_CALC) begin
			base_q <= base_calc;
			st_q   <= st_d;
			col_q  <= '0;
			acc_q  <= '0;
			case (op_q)
				OP_FIRST: delta_q <= prod;
				OP_RIGHT: delta_q <= -(25'(wt_q));
				default:  delta_q <= 25'(wt_q);
			endcase
		end
		if (state_q == S_ADDR) begin
			addr_q <= ADDR_W'(idx);
			st_q   <= st_d;
		end
		if (state_q == S_INT_ACC && out_free) begin
			acc_q <= sat33(int_sum);
			col_q <= col_q + 6'd1;
		end
		if (out_load) begin
			status_q <= ld_status;
			column_q <= ld_col;
			total_q  <= ld_total;
			last_q   <= ld_last;
		end
	end

	// map ram, one port, read data registered
	always_ff @(posedge clk) begin
		if (mem_we)
			map_q[mem_addr] <= mem_wdata;
		rdata_q <= map_q[mem_addr];
	end

	`HMDA_IMPLY(a_clear_blocks_input, state_q == S_CLEAR, !in_ready, "request taken during clear sweep")
	`HMDA_IMPLY(a_mid_column_range, out_valid_q && !last_q, ({1'b0, column_q} + 7'd1) < cfg.w, "running total column past row end")
	`HMDA_IMPLY(a_single_result_form, out_valid_q && status_q != STAT_OK, total_q == '0 && last_q && column_q == '0, "bad dropped or out of bounds result")
	`HMDA_IMPLY(a_write_in_range, mem_we, 32'(mem_addr) < 32'(STORE_DEPTH), "map write past store end")
	`HMDA_NEXT(a_write_then_result, state_q == S_MOD, state_q == S_EMIT, "write back not followed by result")

endmodule
